// ===== src/tse_pkg.sv =====
// shared types, constants and microcode for the taylor series evaluator
package tse_pkg;

  // field widths
  localparam int OP_W  = 2;
  localparam int ARG_W = 32;
  localparam int TC_W  = 6;
  localparam int VAL_W = 48;

  // configuration reset and default term limit
  localparam logic [TC_W-1:0] TC_RESET = 6'd8;
  localparam int MAX_TERMS_DEF = 32;

  // magnitude format, unsigned q15.32
  localparam int MAG_W = 47;
  localparam int MAG_HI_W = MAG_W - 32;
  localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};
  localparam logic [MAG_W-1:0] ONE_Q32 = MAG_W'(64'h1_0000_0000);

  // divider: dividend bits and quotient bits per cycle
  localparam int DVD_W = 56;
  localparam int DIGIT_W = 8;

  // operation codes
  localparam logic [OP_W-1:0] OP_SIN  = 2'd0;
  localparam logic [OP_W-1:0] OP_COS  = 2'd1;
  localparam logic [OP_W-1:0] OP_EXP  = 2'd2;
  localparam logic [OP_W-1:0] OP_SINH = 2'd3;

  // microprogram steps
  localparam int PC_W = 4;
  localparam logic [PC_W-1:0] S_IDLE  = 4'd0;
  localparam logic [PC_W-1:0] S_CHKZ  = 4'd1;
  localparam logic [PC_W-1:0] S_ACC   = 4'd2;
  localparam logic [PC_W-1:0] S_MULLO = 4'd3;
  localparam logic [PC_W-1:0] S_MULHI = 4'd4;
  localparam logic [PC_W-1:0] S_DIVLD = 4'd5;
  localparam logic [PC_W-1:0] S_DIV   = 4'd6;
  localparam logic [PC_W-1:0] S_MAG   = 4'd7;
  localparam logic [PC_W-1:0] S_FIN   = 4'd8;
  localparam logic [PC_W-1:0] S_RET   = 4'd9;

  // jump conditions
  localparam int COND_W = 3;
  localparam logic [COND_W-1:0] C_NEXT    = 3'd0;
  localparam logic [COND_W-1:0] C_JUMP    = 3'd1;
  localparam logic [COND_W-1:0] C_NOIN    = 3'd2;
  localparam logic [COND_W-1:0] C_ZERO    = 3'd3;
  localparam logic [COND_W-1:0] C_LAST    = 3'd4;
  localparam logic [COND_W-1:0] C_DIVMORE = 3'd5;
  localparam logic [COND_W-1:0] C_OUTBUSY = 3'd6;

  // datapath strobes of one control word
  typedef struct packed {
    logic start;
    logic acc;
    logic mul_lo;
    logic mul_hi;
    logic div_load;
    logic div_step;
    logic mag_upd;
    logic out_load;
  } ctrl_t;

  // one microcode word
  typedef struct packed {
    ctrl_t             ctrl;
    logic [COND_W-1:0] cond;
    logic [PC_W-1:0]   target;
  } uword_t;

  // datapath flags seen by the sequencer
  typedef struct packed {
    logic limit_zero;
    logic last_term;
    logic div_more;
  } dp_stat_t;

  // microcode rom
  function automatic uword_t ucode_word(input logic [PC_W-1:0] pc);
    uword_t w;
    w = '0;
    w.cond = C_NEXT;
    w.target = S_IDLE;
    case (pc)
      S_IDLE: begin
        w.ctrl.start = 1'b1;
        w.cond = C_NOIN;
        w.target = S_IDLE;
      end
      S_CHKZ: begin
        w.cond = C_ZERO;
        w.target = S_FIN;
      end
      S_ACC: begin
        w.ctrl.acc = 1'b1;
        w.cond = C_LAST;
        w.target = S_FIN;
      end
      S_MULLO: w.ctrl.mul_lo = 1'b1;
      S_MULHI: w.ctrl.mul_hi = 1'b1;
      S_DIVLD: w.ctrl.div_load = 1'b1;
      S_DIV: begin
        w.ctrl.div_step = 1'b1;
        w.cond = C_DIVMORE;
        w.target = S_DIV;
      end
      S_MAG: begin
        w.ctrl.mag_upd = 1'b1;
        w.cond = C_JUMP;
        w.target = S_ACC;
      end
      S_FIN: begin
        w.ctrl.out_load = 1'b1;
        w.cond = C_OUTBUSY;
        w.target = S_FIN;
      end
      S_RET: begin
        w.cond = C_JUMP;
        w.target = S_IDLE;
      end
      default: begin
        w.cond = C_JUMP;
        w.target = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== src/taylor_series_evaluator.sv =====
// top level: truncated maclaurin series for sine, cosine, exponential and sinh
//
// The input channel takes an operation code on in_tuser and a signed q4.28
// argument on in_tdata. The result channel gives the signed q15.32 sum of
// the first term_count series terms on out_tdata, saturated, and an overflow
// flag on out_tuser. term_count is written through cfg_we/cfg_wdata, by the
// user only while the block is idle; the block itself does not enforce this.
// Values above MAX_TERMS act as MAX_TERMS. The block works on one item at a
// time and takes no new item until the sequencer is back in idle. L terms of
// the power series are walked (L = N for the exponential, 2N otherwise).
// Each term after the first takes one pass through the shared 32x32
// multiplier (two products) and then the divider, which retires eight
// quotient bits a cycle, so the divider sets the pace.
// Reset clears the sequencer and the output valid flag and sets term_count
// to 8. A finished result waits in the output register; while the receiver
// stalls the sequencer holds in its final step and takes no new item.
module taylor_series_evaluator #(
  parameter int MAX_TERMS = tse_pkg::MAX_TERMS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [5:0]  cfg_wdata,   // term_count
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // argument
  input  logic [1:0]  in_tuser,    // operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,   // series_value
  output logic        out_tuser    // overflow
);
  import tse_pkg::*;

  logic [TC_W-1:0]  tc_r;
  logic             out_valid_r;
  logic [VAL_W-1:0] out_value_r;
  logic             out_ovf_r;
  logic             out_busy;
  ctrl_t            ctrl;
  dp_stat_t         dp_stat;
  logic [VAL_W-1:0] res_value;
  logic             res_ovf;

  assign out_busy = out_valid_r & ~out_tready;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tc_r <= TC_RESET;
    end else if (cfg_we) begin
      tc_r <= cfg_wdata;
    end
  end

  tse_sequencer u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .out_busy (out_busy),
    .dp_stat  (dp_stat),
    .ctrl     (ctrl),
    .ready    (in_tready)
  );

  tse_datapath #(
    .MAX_TERMS(MAX_TERMS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .term_count (tc_r),
    .in_op      (in_tuser),
    .in_arg     (in_tdata),
    .dp_stat    (dp_stat),
    .res_value  (res_value),
    .res_ovf    (res_ovf)
  );

  // output register, freed by a transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      out_value_r <= res_value;
      out_ovf_r <= res_ovf;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_value_r;
  assign out_tuser = out_ovf_r;

  // an accepted item blocks the input until its result is written
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input ready right after a transfer");

  // after writing a result the sequencer returns to idle through its return step
  a_idle_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.out_load |-> ##2 in_tready)
    else $error("sequencer did not return to idle");

  // zero terms give zero without overflow
  a_zero_terms: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.out_load && dp_stat.limit_zero) |=> (out_tdata == '0 && !out_tuser))
    else $error("zero term result not zero");

endmodule

// ===== src/tse_sequencer.sv =====
// microcode sequencer: step counter, rom lookup and conditional jumps
module tse_sequencer (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           out_busy,
  input  tse_pkg::dp_stat_t dp_stat,
  output tse_pkg::ctrl_t ctrl,
  output logic           ready
);
  import tse_pkg::*;

  logic [PC_W-1:0] pc_r, pc_nxt;
  uword_t          word;
  logic            take;

  // decode current step
  always_comb begin
    word = ucode_word(pc_r);
    ready = word.ctrl.start;
    ctrl = word.ctrl;
    ctrl.start = word.ctrl.start & in_valid;
    ctrl.out_load = word.ctrl.out_load & ~out_busy;
  end

  // jump condition select
  always_comb begin
    case (word.cond)
      C_NEXT:    take = 1'b0;
      C_JUMP:    take = 1'b1;
      C_NOIN:    take = ~in_valid;
      C_ZERO:    take = dp_stat.limit_zero;
      C_LAST:    take = dp_stat.last_term;
      C_DIVMORE: take = dp_stat.div_more;
      C_OUTBUSY: take = out_busy;
      default:   take = 1'b1;
    endcase
    pc_nxt = take ? word.target : pc_r + PC_W'(1);
  end

  // step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= S_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// ===== src/tse_divider.sv =====
// digit-serial unsigned divider by a narrow divisor, several quotient bits per step
module tse_divider #(
  parameter int DIV_W = 7
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      load,
  input  logic                      step,
  input  logic [tse_pkg::DVD_W-1:0] dividend,
  input  logic [DIV_W-1:0]          divisor,
  output logic [tse_pkg::DVD_W-1:0] quotient,
  output logic                      more
);
  import tse_pkg::*;

  localparam int STEPS = DVD_W / DIGIT_W;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic [DVD_W-1:0] dvd_r, dvd_nxt;
  logic [DIV_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [DIV_W:0]   trial;

  // one digit of restoring division, quotient bits shift into the dividend
  always_comb begin
    rem_nxt = rem_r;
    dvd_nxt = dvd_r;
    trial = '0;
    for (int i = 0; i < DIGIT_W; i++) begin
      trial = {rem_nxt, dvd_nxt[DVD_W-1]};
      dvd_nxt = {dvd_nxt[DVD_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        trial = trial - {1'b0, divisor};
        dvd_nxt[0] = 1'b1;
      end
      rem_nxt = trial[DIV_W-1:0];
    end
  end

  assign more = (cnt_r != CNT_W'(STEPS - 1));
  assign quotient = dvd_r;

  // digit counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load) begin
      cnt_r <= '0;
    end else if (step) begin
      cnt_r <= more ? cnt_r + CNT_W'(1) : '0;
    end
  end

  // dividend and partial remainder
  always_ff @(posedge clk) begin
    if (load) begin
      dvd_r <= dividend;
      rem_r <= '0;
    end else if (step) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
  end

endmodule

// ===== src/tse_datapath.sv =====
// term recurrence datapath: shared multiplier, divider, magnitude and sum registers
module tse_datapath #(
  parameter int MAX_TERMS = tse_pkg::MAX_TERMS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  tse_pkg::ctrl_t            ctrl,
  input  logic [tse_pkg::TC_W-1:0]  term_count,
  input  logic [tse_pkg::OP_W-1:0]  in_op,
  input  logic [tse_pkg::ARG_W-1:0] in_arg,
  output tse_pkg::dp_stat_t         dp_stat,
  output logic [tse_pkg::VAL_W-1:0] res_value,
  output logic                      res_ovf
);
  import tse_pkg::*;

  localparam int LIM_W = $clog2(2 * MAX_TERMS + 1);
  localparam int SUM_W = VAL_W + LIM_W + 1;
  localparam int PART_W = 64 - 28;

  logic [OP_W-1:0]  op_r;
  logic             xneg_r;
  logic [ARG_W-1:0] ax_r;
  logic [LIM_W-1:0] lim_r, k_r;
  logic [MAG_W-1:0] mag_r;
  logic [SUM_W-1:0] sum_r;
  logic             ovf_r;
  logic [63:0]      mul_r;
  logic [PART_W-1:0] part_r;

  logic [LIM_W-1:0] n_terms, limit;
  logic [ARG_W-1:0] ax;
  logic [31:0]      mul_a;
  logic [DVD_W-1:0] dividend, quotient;
  logic             div_more;
  logic             use_term, neg_term;
  logic [SUM_W-1:0] term_ext;
  logic             sum_sat;

  // term limit and argument magnitude at accept
  always_comb begin
    n_terms = (int'(term_count) > MAX_TERMS) ? LIM_W'(MAX_TERMS) : LIM_W'(term_count);
    limit = (in_op == OP_EXP) ? n_terms : LIM_W'({n_terms, 1'b0});
    ax = in_arg[ARG_W-1] ? (~in_arg + ARG_W'(1)) : in_arg;
  end

  // which terms count and with what sign
  always_comb begin
    case (op_r)
      OP_EXP:  use_term = 1'b1;
      OP_COS:  use_term = ~k_r[0];
      default: use_term = k_r[0];
    endcase
    neg_term = xneg_r & k_r[0];
    if ((op_r == OP_SIN || op_r == OP_COS) && k_r[1]) begin
      neg_term = ~neg_term;
    end
    term_ext = SUM_W'(mag_r);
  end

  // shared multiplier operand: low or high word of the magnitude
  assign mul_a = ctrl.mul_hi ? 32'(mag_r[MAG_W-1:32]) : mag_r[31:0];

  // product realigned to q15.32 before the divide
  assign dividend = DVD_W'({mul_r, 4'b0000}) + DVD_W'(part_r);

  tse_divider #(
    .DIV_W(LIM_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (ctrl.div_load),
    .step     (ctrl.div_step),
    .dividend (dividend),
    .divisor  (k_r),
    .quotient (quotient),
    .more     (div_more)
  );

  // argument, limit and term index
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      op_r <= in_op;
      xneg_r <= in_arg[ARG_W-1];
      ax_r <= ax;
      lim_r <= limit;
      k_r <= '0;
    end else if (ctrl.acc) begin
      k_r <= k_r + LIM_W'(1);
    end
  end

  // multiplier and partial product registers
  always_ff @(posedge clk) begin
    if (ctrl.mul_lo || ctrl.mul_hi) begin
      mul_r <= 64'(mul_a) * 64'(ax_r);
    end
    if (ctrl.mul_hi) begin
      part_r <= mul_r[63:28];
    end
  end

  // magnitude, sum and overflow
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      mag_r <= ONE_Q32;
      sum_r <= '0;
      ovf_r <= 1'b0;
    end else begin
      if (ctrl.acc && use_term) begin
        sum_r <= neg_term ? sum_r - term_ext : sum_r + term_ext;
      end
      if (ctrl.mag_upd) begin
        if (|quotient[DVD_W-1:MAG_W]) begin
          mag_r <= MAG_MAX;
          ovf_r <= 1'b1;
        end else begin
          mag_r <= quotient[MAG_W-1:0];
        end
      end
    end
  end

  // saturation of the final sum to 48 bits
  always_comb begin
    sum_sat = ~((&sum_r[SUM_W-1:VAL_W-1]) | ~(|sum_r[SUM_W-1:VAL_W-1]));
    if (sum_sat) begin
      res_value = sum_r[SUM_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
    end else begin
      res_value = sum_r[VAL_W-1:0];
    end
    res_ovf = ovf_r | sum_sat;
  end

  // flags for the sequencer
  always_comb begin
    dp_stat.limit_zero = (lim_r == '0);
    dp_stat.last_term = ((k_r + LIM_W'(1)) == lim_r);
    dp_stat.div_more = div_more;
  end

endmodule

// ===== verif/taylor_series_evaluator_tb.sv =====
// self-checking testbench for the taylor series evaluator: directed table then random phases
`timescale 1ns / 1ps

module taylor_series_evaluator_tb;
  import tse_pkg::*;

  localparam int TERM_CAP = MAX_TERMS_DEF;
  localparam logic [63:0] MAG_CEIL = 64'h0000_7FFF_FFFF_FFFF;
  localparam logic [63:0] UNIT_Q32 = 64'h0000_0001_0000_0000;
  localparam longint SUM_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SUM_LO = -64'sh0000_8000_0000_0000;
  localparam logic [47:0] VAL_ONE = 48'h0001_0000_0000;
  localparam logic [47:0] VAL_MINUS_ONE = 48'hFFFF_0000_0000;
  localparam int IDLE_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 50;

  // one expected result
  typedef struct {
    logic [47:0] value;
    logic        ovf;
  } series_result_t;

  // one row of the directed table
  typedef struct {
    logic [5:0]  terms;
    logic [1:0]  op;
    logic [31:0] arg;
    bit          known;
    logic [47:0] value;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [5:0]  cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;    // argument
  logic [1:0]  in_tuser = '0;    // operation
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;        // series_value
  logic        out_tuser;        // overflow

  series_result_t results_due[$];
  logic [5:0] terms_now = TC_RESET;
  int  fail_count = 0;
  int  results_seen = 0;
  int  op_count [4] = '{0, 0, 0, 0};
  bit  calm = 1'b0;
  bit  hold_req = 1'b0;

  taylor_series_evaluator uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // truncated maclaurin sum, magnitude recurrence with truncating multiply and divide
  function automatic series_result_t predict_series(input logic [1:0] op,
                                                    input logic [31:0] arg,
                                                    input logic [5:0] terms);
    series_result_t res;
    logic [63:0] ax;
    logic [63:0] mag;
    logic [63:0] prod;
    int          n_terms;
    int          walk;
    longint      sum;
    bit          xneg;
    bit          take;
    bit          neg;
    res.ovf = 1'b0;
    xneg = arg[31];
    ax = xneg ? (UNIT_Q32 - {32'd0, arg}) : {32'd0, arg};
    n_terms = (int'(terms) > TERM_CAP) ? TERM_CAP : int'(terms);
    walk = (op == OP_EXP) ? n_terms : 2 * n_terms;
    mag = UNIT_Q32;
    sum = 0;
    for (int k = 0; k < walk; k++) begin
      if (k > 0) begin
        prod = (((mag >> 32) * ax) << 4) + (((mag & 64'hFFFF_FFFF) * ax) >> 28);
        prod = prod / 64'(k);
        if (prod > MAG_CEIL) begin
          res.ovf = 1'b1;
          prod = MAG_CEIL;
        end
        mag = prod;
      end
      case (op)
        OP_EXP:  take = 1'b1;
        OP_COS:  take = (k % 2) == 0;
        default: take = (k % 2) == 1;
      endcase
      if (take) begin
        neg = xneg && ((k % 2) == 1);
        // sine and cosine alternate every second power
        if ((op == OP_SIN || op == OP_COS) && ((k / 2) % 2 == 1)) neg = !neg;
        if (neg) sum -= longint'(mag);
        else sum += longint'(mag);
      end
    end
    if (sum > SUM_HI) begin
      sum = SUM_HI;
      res.ovf = 1'b1;
    end else if (sum < SUM_LO) begin
      sum = SUM_LO;
      res.ovf = 1'b1;
    end
    res.value = sum[47:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  // wait for all results, then write the term count while the block is idle
  task automatic write_terms(input logic [5:0] terms);
    in_tvalid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= terms;
    @(posedge clk);
    cfg_we <= 1'b0;
    terms_now = terms;
  endtask

  // offer one item and hold it until the transfer; valid stays high afterwards
  task automatic send_item(input logic [1:0] op, input logic [31:0] arg,
                           input bit known, input logic [47:0] value);
    series_result_t due;
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= arg;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (known) begin
      due.value = value;
      due.ovf = 1'b0;
    end else begin
      due = predict_series(op, arg, terms_now);
    end
    results_due.push_back(due);
    op_count[op]++;
  endtask

  // random sender gap
  task automatic maybe_pause();
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] pick_argument();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'h8000_0000;
      2: return 32'h7FFF_FFFF;
      3, 4: return 32'($signed($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000);
      default: return $urandom;
    endcase
  endfunction

  // result side: check each transfer, then decide ready for the next edge
  initial begin : result_side
    int stall_left;
    series_result_t due;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (results_due.size() == 0) begin
          report_mismatch($sformatf("unexpected result value=%h ovf=%b", out_tdata, out_tuser));
        end else begin
          due = results_due.pop_front();
          if (out_tdata !== due.value)
            report_mismatch($sformatf("series_value %h, expected %h", out_tdata, due.value));
          if (out_tuser !== due.ovf)
            report_mismatch($sformatf("overflow %b, expected %b", out_tuser, due.ovf));
        end
      end
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 6) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no transfer on either side
  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
      if (quiet >= IDLE_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // stimulus
  initial begin : stimulus
    dir_row_t dir_rows [];
    logic [5:0] phase_terms [PHASES];
    dir_rows = '{
      // reset term count: zero argument gives the constant term only, then two nonzero arguments
      '{6'd8,  OP_COS,  32'h0000_0000, 1'b1, VAL_ONE},
      '{6'd8,  OP_EXP,  32'h0000_0000, 1'b1, VAL_ONE},
      '{6'd8,  OP_SIN,  32'h0000_0000, 1'b1, 48'd0},
      '{6'd8,  OP_SINH, 32'h0000_0000, 1'b1, 48'd0},
      '{6'd8,  OP_SIN,  32'h1000_0000, 1'b0, 48'd0},
      '{6'd8,  OP_EXP,  32'h8000_0000, 1'b0, 48'd0},
      // zero terms
      '{6'd0,  OP_EXP,  32'h7FFF_FFFF, 1'b1, 48'd0},
      '{6'd0,  OP_SIN,  32'h8000_0000, 1'b1, 48'd0},
      '{6'd0,  OP_COS,  32'h0000_0000, 1'b1, 48'd0},
      // one term
      '{6'd1,  OP_EXP,  32'h7FFF_FFFF, 1'b1, VAL_ONE},
      '{6'd1,  OP_COS,  32'h8000_0000, 1'b1, VAL_ONE},
      '{6'd1,  OP_SIN,  32'h1000_0000, 1'b1, VAL_ONE},
      '{6'd1,  OP_SINH, 32'hF000_0000, 1'b1, VAL_MINUS_ONE},
      // full series at the argument extremes and near zero
      '{6'd32, OP_SIN,  32'h7FFF_FFFF, 1'b0, 48'd0},
      '{6'd32, OP_COS,  32'h8000_0000, 1'b0, 48'd0},
      '{6'd32, OP_EXP,  32'h7FFF_FFFF, 1'b0, 48'd0},
      '{6'd32, OP_SINH, 32'h8000_0000, 1'b0, 48'd0},
      '{6'd32, OP_COS,  32'h0000_0000, 1'b1, VAL_ONE},
      '{6'd32, OP_EXP,  32'h0000_0001, 1'b0, 48'd0},
      // term counts above the cap
      '{6'd63, OP_EXP,  32'h8000_0000, 1'b0, 48'd0},
      '{6'd63, OP_SINH, 32'h7FFF_FFFF, 1'b0, 48'd0},
      '{6'd33, OP_COS,  32'h0000_0001, 1'b0, 48'd0}
    };
    phase_terms[0] = 6'd6;
    phase_terms[1] = 6'd32;
    phase_terms[2] = 6'd0;
    phase_terms[3] = 6'd63;
    phase_terms[4] = 6'd1;
    phase_terms[5] = 6'($urandom_range(2, 10));
    phase_terms[6] = 6'($urandom_range(0, 63));
    phase_terms[7] = 6'($urandom_range(2, 16));

    // reset
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].terms != terms_now) write_terms(dir_rows[i].terms);
      send_item(dir_rows[i].op, dir_rows[i].arg, dir_rows[i].known, dir_rows[i].value);
      maybe_pause();
    end

    // random phases, one term count each
    for (int p = 0; p < PHASES; p++) begin
      write_terms(phase_terms[p]);
      if (p == PHASES - 1) calm = 1'b1;
      // long receiver hold-off while items keep coming
      if (p == 5) hold_req = 1'b1;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        send_item(2'($urandom_range(0, 3)), pick_argument(), 1'b0, 48'd0);
        maybe_pause();
      end
    end

    // drain
    in_tvalid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (results_due.size() != 0) report_mismatch("expected results left over");

    $display("covered %0d items: sine %0d, cosine %0d, exponential %0d, sinh %0d",
             op_count[0] + op_count[1] + op_count[2] + op_count[3],
             op_count[0], op_count[1], op_count[2], op_count[3]);
    $display("term counts 0 to 63 incl. above the cap, %0d results checked, %0d mismatches",
             results_seen, fail_count);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== taylor_series_evaluator.f =====
src/tse_pkg.sv
src/tse_sequencer.sv
src/tse_divider.sv
src/tse_datapath.sv
src/taylor_series_evaluator.sv
verif/taylor_series_evaluator_tb.sv
